@@ src/tpf_pkg.sv @@
// ---------------------------------------------------------------------------
// tpf_pkg
// Shared types and constants for the triangle pixel fragment test block.
// ---------------------------------------------------------------------------
package tpf_pkg;

  localparam int unsigned DataW     = 32;
  localparam int unsigned PixInW    = 10;
  localparam int unsigned CoefIdxW  = 5;
  localparam int unsigned ColorW    = 16;
  localparam int unsigned CoordBits = 10;
  localparam int unsigned FracBits  = 10;
  localparam int unsigned NumCoefs  = 21;
  // coordinate bits actually taken from the pixel ports
  localparam int unsigned XBits     = (CoordBits < PixInW) ? CoordBits : PixInW;

  localparam int unsigned RedW      = 5;
  localparam int unsigned GreenW    = 6;
  localparam int unsigned BlueW     = 5;

  // coefficient slots
  localparam int unsigned SlotEdge0 = 0;
  localparam int unsigned SlotEdge1 = 3;
  localparam int unsigned SlotEdge2 = 6;
  localparam int unsigned SlotDepth = 9;
  localparam int unsigned SlotRed   = 12;
  localparam int unsigned SlotGreen = 15;
  localparam int unsigned SlotBlue  = 18;

  typedef enum logic {
    ActLoad  = 1'b0,
    ActPixel = 1'b1
  } action_e;

  typedef logic [NumCoefs-1:0][DataW-1:0] coef_bank_t;

  typedef struct packed {
    logic              write_pixel;
    logic [DataW-1:0]  new_depth;
    logic [ColorW-1:0] pixel_color;
  } frag_res_t;

  typedef struct packed {
    logic [XBits-1:0] x;
    logic [XBits-1:0] y;
    logic [DataW-1:0] stored_depth;
  } frag_in_t;

endpackage

@@ src/tpf_ifs.sv @@
// ---------------------------------------------------------------------------
// tpf_ifs
// Valid/ready channels for fragment items and fragment results.
// ---------------------------------------------------------------------------
interface tpf_in_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [tpf_pkg::CoefIdxW-1:0] coef_index;
  logic [tpf_pkg::DataW-1:0]    coef_value;
  logic [tpf_pkg::PixInW-1:0]   pixel_x;
  logic [tpf_pkg::PixInW-1:0]   pixel_y;
  logic [tpf_pkg::DataW-1:0]    stored_depth;

  modport source (output valid, action, coef_index, coef_value, pixel_x, pixel_y,
                  stored_depth, input ready);
  modport sink   (input valid, action, coef_index, coef_value, pixel_x, pixel_y,
                  stored_depth, output ready);
endinterface

interface tpf_out_if;
  logic                       valid;
  logic                       ready;
  logic                       write_pixel;
  logic [tpf_pkg::DataW-1:0]  new_depth;
  logic [tpf_pkg::ColorW-1:0] pixel_color;

  modport source (output valid, write_pixel, new_depth, pixel_color, input ready);
  modport sink   (input valid, write_pixel, new_depth, pixel_color, output ready);
endinterface

@@ src/triangle_pixel_fragment_test.sv @@
// ---------------------------------------------------------------------------
// triangle_pixel_fragment_test
// Per-pixel half-space triangle test with depth compare and RGB565 shading.
// ---------------------------------------------------------------------------
//  channel   dir   handshake      transaction
//  in_ch_i   in    valid/ready    coefficient load or pixel
//  out_ch_o  out   valid/ready    one result per pixel, none per load
//
// one item per cycle while input ready is high; a pixel is held in the pixel
// register from its acceptance edge, its result then moves to the result register
// and is taken from there by the output; a load takes effect at acceptance
// reset clears the coefficient bank to zero and empties both stages
// a stalled result holds the pixel register; input ready drops only when
// both the pixel stage and the result register are full and not draining
// ---------------------------------------------------------------------------
module triangle_pixel_fragment_test (
  input  logic       clk_i,
  input  logic       rst_ni,
  tpf_in_if.sink     in_ch_i,
  tpf_out_if.source  out_ch_o
);

  tpf_pkg::coef_bank_t coef;
  tpf_pkg::frag_in_t   frag_q;
  tpf_pkg::frag_res_t  res;
  tpf_pkg::frag_res_t  res_q;
  logic                frag_vld_q;
  logic                res_vld_q;
  logic                res_free;
  logic                frag_adv;
  logic                in_acc;
  logic                coef_we;
  logic                pix_acc;

  assign res_free = !res_vld_q || out_ch_o.ready;
  assign frag_adv = frag_vld_q && res_free;
  // loads may only land once any waiting pixel has been shaded
  assign in_ch_i.ready = !frag_vld_q || res_free;
  assign in_acc   = in_ch_i.valid && in_ch_i.ready;
  assign coef_we  = in_acc && (in_ch_i.action == tpf_pkg::ActLoad);
  assign pix_acc  = in_acc && (in_ch_i.action == tpf_pkg::ActPixel);

  tpf_coef_regs u_coef (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (coef_we),
    .idx_i  (in_ch_i.coef_index),
    .data_i (in_ch_i.coef_value),
    .coef_o (coef)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frag_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      if (in_ch_i.ready) begin
        frag_vld_q <= pix_acc;
      end
      if (res_free) begin
        res_vld_q <= frag_adv;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      frag_q.x            <= in_ch_i.pixel_x[tpf_pkg::XBits-1:0];
      frag_q.y            <= in_ch_i.pixel_y[tpf_pkg::XBits-1:0];
      frag_q.stored_depth <= in_ch_i.stored_depth;
    end
    if (frag_adv) begin
      res_q <= res;
    end
  end

  tpf_shade u_shade (
    .frag_i (frag_q),
    .coef_i (coef),
    .res_o  (res)
  );

  assign out_ch_o.valid       = res_vld_q;
  assign out_ch_o.write_pixel = res_q.write_pixel;
  assign out_ch_o.new_depth   = res_q.new_depth;
  assign out_ch_o.pixel_color = res_q.pixel_color;

endmodule

@@ src/tpf_coef_regs.sv @@
// ---------------------------------------------------------------------------
// tpf_coef_regs
// Per-triangle plane coefficient bank, written one slot per load transaction.
// ---------------------------------------------------------------------------
module tpf_coef_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                we_i,
  input  logic [tpf_pkg::CoefIdxW-1:0]        idx_i,
  input  logic [tpf_pkg::DataW-1:0]           data_i,
  output tpf_pkg::coef_bank_t                 coef_o
);

  tpf_pkg::coef_bank_t coef_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else if (we_i) begin
      // slots above the last one are dropped
      for (int i = 0; i < tpf_pkg::NumCoefs; i++) begin
        if (idx_i == tpf_pkg::CoefIdxW'(i)) begin
          coef_q[i] <= data_i;
        end
      end
    end
  end

  assign coef_o = coef_q;

endmodule

@@ src/tpf_plane.sv @@
// ---------------------------------------------------------------------------
// tpf_plane
// One plane evaluation: x*dx + y*dy, wrapping at 32 bits.
// ---------------------------------------------------------------------------
module tpf_plane (
  input  logic [tpf_pkg::XBits-1:0] x_i,
  input  logic [tpf_pkg::XBits-1:0] y_i,
  input  logic [tpf_pkg::DataW-1:0] dx_i,
  input  logic [tpf_pkg::DataW-1:0] dy_i,
  output logic [tpf_pkg::DataW-1:0] sum_o
);

  logic [tpf_pkg::DataW-1:0] x_ext;
  logic [tpf_pkg::DataW-1:0] y_ext;

  assign x_ext = tpf_pkg::DataW'(x_i);
  assign y_ext = tpf_pkg::DataW'(y_i);
  assign sum_o = (x_ext * dx_i) + (y_ext * dy_i);

endmodule

@@ src/tpf_shade.sv @@
// ---------------------------------------------------------------------------
// tpf_shade
// Edge and depth tests plus RGB565 shading for one registered pixel.
// ---------------------------------------------------------------------------
module tpf_shade (
  input  tpf_pkg::frag_in_t   frag_i,
  input  tpf_pkg::coef_bank_t coef_i,
  output tpf_pkg::frag_res_t  res_o
);

  localparam int unsigned NumPlanes = 7;

  // plane order: edge0, edge1, edge2, depth, red, green, blue
  localparam int unsigned PlaneBase [NumPlanes] = '{
    tpf_pkg::SlotEdge0, tpf_pkg::SlotEdge1, tpf_pkg::SlotEdge2, tpf_pkg::SlotDepth,
    tpf_pkg::SlotRed, tpf_pkg::SlotGreen, tpf_pkg::SlotBlue
  };

  logic [tpf_pkg::DataW-1:0] xy   [NumPlanes];
  logic [tpf_pkg::DataW-1:0] edge_v [3];
  logic [2:0]                outside;
  logic [tpf_pkg::DataW-1:0] z;
  logic [tpf_pkg::DataW-1:0] red_v;
  logic [tpf_pkg::DataW-1:0] green_v;
  logic [tpf_pkg::DataW-1:0] blue_v;
  logic                      depth_ok;
  logic                      draw;

  for (genvar p = 0; p < NumPlanes; p++) begin : g_plane
    tpf_plane u_plane (
      .x_i   (frag_i.x),
      .y_i   (frag_i.y),
      .dx_i  (coef_i[PlaneBase[p]]),
      .dy_i  (coef_i[PlaneBase[p] + 1]),
      .sum_o (xy[p])
    );
  end

  for (genvar e = 0; e < 3; e++) begin : g_edge
    assign edge_v[e]  = xy[e] - coef_i[PlaneBase[e] + 2];
    // strictly positive means outside, zero counts as inside
    assign outside[e] = !edge_v[e][tpf_pkg::DataW-1] && (edge_v[e] != '0);
  end

  assign z        = xy[3] + coef_i[tpf_pkg::SlotDepth + 2];
  assign red_v    = xy[4] + coef_i[tpf_pkg::SlotRed + 2];
  assign green_v  = xy[5] + coef_i[tpf_pkg::SlotGreen + 2];
  assign blue_v   = xy[6] + coef_i[tpf_pkg::SlotBlue + 2];
  assign depth_ok = $signed(z) >= $signed(frag_i.stored_depth);
  assign draw     = (outside == '0) && depth_ok;

  always_comb begin
    res_o = '0;
    if (draw) begin
      res_o.write_pixel = 1'b1;
      res_o.new_depth   = z;
      res_o.pixel_color = {red_v[tpf_pkg::FracBits +: tpf_pkg::RedW],
                           green_v[tpf_pkg::FracBits +: tpf_pkg::GreenW],
                           blue_v[tpf_pkg::FracBits +: tpf_pkg::BlueW]};
    end
  end

endmodule

@@ bench/triangle_pixel_fragment_test_tb.sv @@
// ---------------------------------------------------------------------------
// triangle_pixel_fragment_test_tb
// Loads triangle plane coefficients and sends pixels through the fragment
// stage. A shadow coefficient bank predicts the edge, depth and RGB565 result
// of every accepted pixel. Each result is checked in order against that
// prediction, with random gaps on the input and random stalls on the output.
// ---------------------------------------------------------------------------
module triangle_pixel_fragment_test_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    tpf_pkg::action_e act;
    logic [4:0]       idx;
    logic [31:0]      value;
    logic [9:0]       px;
    logic [9:0]       py;
    logic [31:0]      depth;
  } frag_item_t;

  logic clk_i;
  logic rst_ni;

  tpf_in_if  in_ch ();
  tpf_out_if out_ch ();

  triangle_pixel_fragment_test DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch_i  (in_ch),
    .out_ch_o (out_ch)
  );

  tpf_pkg::coef_bank_t coef_bank;
  tpf_pkg::frag_res_t  shade_q[$];
  int                  fail_cnt;
  int                  item_cnt;
  bit                  calm;

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // x*c[base] + y*c[base+1], wrapping at 32 bits
  function automatic logic [31:0] plane_at(tpf_pkg::coef_bank_t c, int unsigned base,
                                           logic [9:0] px, logic [9:0] py);
    logic [31:0] x;
    logic [31:0] y;
    x = 32'(px[tpf_pkg::XBits-1:0]);
    y = 32'(py[tpf_pkg::XBits-1:0]);
    return x * c[base] + y * c[base+1];
  endfunction

  function automatic tpf_pkg::frag_res_t shade_fragment(tpf_pkg::coef_bank_t c,
                                                        frag_item_t it);
    tpf_pkg::frag_res_t res;
    logic [31:0]        edge_v;
    logic [31:0]        z;
    logic [31:0]        r;
    logic [31:0]        g;
    logic [31:0]        b;
    bit                 hit;
    hit = 1'b1;
    for (int e = 0; e < 3; e++) begin
      edge_v = plane_at(c, tpf_pkg::SlotEdge0 + 3 * e, it.px, it.py)
             - c[tpf_pkg::SlotEdge0 + 3 * e + 2];
      if ($signed(edge_v) > 0) hit = 1'b0;
    end
    z = plane_at(c, tpf_pkg::SlotDepth, it.px, it.py) + c[tpf_pkg::SlotDepth + 2];
    if ($signed(z) < $signed(it.depth)) hit = 1'b0;
    res = '0;
    if (hit) begin
      r = plane_at(c, tpf_pkg::SlotRed, it.px, it.py) + c[tpf_pkg::SlotRed + 2];
      g = plane_at(c, tpf_pkg::SlotGreen, it.px, it.py) + c[tpf_pkg::SlotGreen + 2];
      b = plane_at(c, tpf_pkg::SlotBlue, it.px, it.py) + c[tpf_pkg::SlotBlue + 2];
      res.write_pixel = 1'b1;
      res.new_depth   = z;
      res.pixel_color = {r[tpf_pkg::FracBits +: tpf_pkg::RedW],
                         g[tpf_pkg::FracBits +: tpf_pkg::GreenW],
                         b[tpf_pkg::FracBits +: tpf_pkg::BlueW]};
    end
    return res;
  endfunction

  // result checker and predictor, both on the rising edge
  always @(posedge clk_i) begin
    frag_item_t         it;
    tpf_pkg::frag_res_t want;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        if (shade_q.size() == 0) begin
          $display("%0t: unexpected result write=%0b depth=%h color=%h", $realtime,
                   out_ch.write_pixel, out_ch.new_depth, out_ch.pixel_color);
          fail_cnt++;
        end else begin
          want = shade_q.pop_front();
          if (out_ch.write_pixel !== want.write_pixel) begin
            $display("%0t: write_pixel expected %0b actual %0b", $realtime,
                     want.write_pixel, out_ch.write_pixel);
            fail_cnt++;
          end
          if (out_ch.new_depth !== want.new_depth) begin
            $display("%0t: new_depth expected %h actual %h", $realtime,
                     want.new_depth, out_ch.new_depth);
            fail_cnt++;
          end
          if (out_ch.pixel_color !== want.pixel_color) begin
            $display("%0t: pixel_color expected %h actual %h", $realtime,
                     want.pixel_color, out_ch.pixel_color);
            fail_cnt++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        it.act   = tpf_pkg::action_e'(in_ch.action);
        it.idx   = in_ch.coef_index;
        it.value = in_ch.coef_value;
        it.px    = in_ch.pixel_x;
        it.py    = in_ch.pixel_y;
        it.depth = in_ch.stored_depth;
        if (it.act == tpf_pkg::ActLoad) begin
          if (it.idx < tpf_pkg::NumCoefs) coef_bank[it.idx] = it.value;
        end else begin
          shade_q.push_back(shade_fragment(coef_bank, it));
        end
      end
    end
  end

  // output stalls
  always @(negedge clk_i) begin
    out_ch.ready <= calm || ($urandom_range(99) >= 15);
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(frag_item_t it);
    while (!calm && $urandom_range(99) < 15) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.action       <= it.act;
    in_ch.coef_index   <= it.idx;
    in_ch.coef_value   <= it.value;
    in_ch.pixel_x      <= it.px;
    in_ch.pixel_y      <= it.py;
    in_ch.stored_depth <= it.depth;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    item_cnt++;
    @(negedge clk_i);
  endtask

  task automatic load_coef(logic [4:0] idx, logic [31:0] value);
    frag_item_t it;
    it.act   = tpf_pkg::ActLoad;
    it.idx   = idx;
    it.value = value;
    it.px    = 10'($urandom());
    it.py    = 10'($urandom());
    it.depth = $urandom();
    send_item(it);
  endtask

  task automatic shade_pixel(logic [9:0] px, logic [9:0] py, logic [31:0] depth);
    frag_item_t it;
    it.act   = tpf_pkg::ActPixel;
    it.idx   = 5'($urandom());
    it.value = $urandom();
    it.px    = px;
    it.py    = py;
    it.depth = depth;
    send_item(it);
  endtask

  task automatic test_reset_bank();
    // all planes zero: every pixel sits on all edges at depth zero
    shade_pixel(10'd0, 10'd0, 32'd0);
    shade_pixel(10'h3ff, 10'h3ff, 32'd1);
  endtask

  task automatic test_edge_limits();
    load_coef(5'(tpf_pkg::SlotEdge0), 32'd1);
    load_coef(5'(tpf_pkg::SlotEdge0 + 2), 32'd5);
    shade_pixel(10'd5, 10'd0, 32'h8000_0000);  // edge exactly zero
    shade_pixel(10'd6, 10'd0, 32'h8000_0000);
    load_coef(5'(tpf_pkg::SlotEdge1 + 1), 32'hffff_ffff);
    load_coef(5'(tpf_pkg::SlotEdge1 + 2), -32'sd7);
    shade_pixel(10'd0, 10'd7, 32'h8000_0000);
    shade_pixel(10'd0, 10'd6, 32'h8000_0000);
    // products wrap: 2 * 0x7fffffff is -2
    load_coef(5'(tpf_pkg::SlotEdge2), 32'h7fff_ffff);
    shade_pixel(10'd2, 10'd7, 32'h8000_0000);
    shade_pixel(10'd1, 10'd7, 32'h8000_0000);
  endtask

  task automatic test_depth_compare();
    load_coef(5'(tpf_pkg::SlotDepth + 2), 32'h7fff_ffff);
    shade_pixel(10'd0, 10'd7, 32'h7fff_ffff);
    shade_pixel(10'd0, 10'd7, 32'h8000_0000);
    load_coef(5'(tpf_pkg::SlotDepth + 2), 32'h8000_0000);
    shade_pixel(10'd0, 10'd7, 32'h8000_0000);
    shade_pixel(10'd0, 10'd7, 32'h8000_0001);
  endtask

  task automatic test_color_wrap();
    load_coef(5'(tpf_pkg::SlotRed + 2), 32'hffff_ffff);
    load_coef(5'(tpf_pkg::SlotGreen + 2), 32'h0000_fc00);
    load_coef(5'(tpf_pkg::SlotBlue + 1), 32'd1 << tpf_pkg::FracBits);
    load_coef(5'(tpf_pkg::SlotBlue + 2), 32'd1 << tpf_pkg::FracBits);
    shade_pixel(10'd0, 10'h3ff, 32'h8000_0000);
  endtask

  task automatic test_index_range();
    load_coef(5'(tpf_pkg::NumCoefs), 32'hffff_ffff);
    load_coef('1, 32'hffff_ffff);
    shade_pixel(10'd0, 10'h3ff, 32'h8000_0000);
  endtask

  task automatic test_random_triangles();
    int          order[$];
    int          cx;
    int          cy;
    int          a;
    int          b;
    int          tri_cnt;
    int          px;
    int          py;
    int          mode;
    logic [31:0] coef_set[tpf_pkg::NumCoefs];
    logic [31:0] z;
    logic [31:0] depth;
    tri_cnt = 0;
    while (item_cnt < 470) begin
      calm = (tri_cnt < 3);
      cx = $urandom_range(1023);
      cy = $urandom_range(1023);
      if ($urandom_range(7) == 0) begin
        // noise: a few raw loads, out-of-range slots among them
        repeat ($urandom_range(1, 8)) load_coef(5'($urandom()), $urandom());
      end else begin
        for (int e = 0; e < 3; e++) begin
          a = int'($urandom_range(64)) - 32;
          b = int'($urandom_range(64)) - 32;
          coef_set[3 * e]     = a;
          coef_set[3 * e + 1] = b;
          coef_set[3 * e + 2] = a * cx + b * cy + int'($urandom_range(2000));
        end
        coef_set[tpf_pkg::SlotDepth]     = int'($urandom_range(1024)) - 512;
        coef_set[tpf_pkg::SlotDepth + 1] = int'($urandom_range(1024)) - 512;
        coef_set[tpf_pkg::SlotDepth + 2] = $urandom();
        for (int k = tpf_pkg::SlotRed; k < tpf_pkg::NumCoefs; k++) begin
          coef_set[k] = ((k - tpf_pkg::SlotRed) % 3 == 2) ? $urandom()
                                                          : int'($urandom_range(8191)) - 4096;
        end
        order.delete();
        for (int k = 0; k < tpf_pkg::NumCoefs; k++) order.push_back(k);
        order.shuffle();
        foreach (order[k]) begin
          if ($urandom_range(15) == 0) begin
            load_coef(5'($urandom_range(31, tpf_pkg::NumCoefs)), $urandom());
          end
          load_coef(5'(order[k]), coef_set[order[k]]);
        end
      end
      repeat ($urandom_range(8, 40)) begin
        mode = $urandom_range(9);
        if (mode == 0) begin
          px = $urandom_range(1023);
          py = $urandom_range(1023);
        end else if (mode == 1) begin
          px = $urandom_range(1) ? 1023 : 0;
          py = $urandom_range(1) ? 1023 : 0;
        end else begin
          px = cx + int'($urandom_range(96)) - 48;
          py = cy + int'($urandom_range(96)) - 48;
          px = (px < 0) ? 0 : (px > 1023) ? 1023 : px;
          py = (py < 0) ? 0 : (py > 1023) ? 1023 : py;
        end
        z = plane_at(coef_bank, tpf_pkg::SlotDepth, 10'(px), 10'(py))
          + coef_bank[tpf_pkg::SlotDepth + 2];
        depth = ($urandom_range(4) == 0) ? $urandom() : z + int'($urandom_range(6)) - 3;
        shade_pixel(10'(px), 10'(py), depth);
      end
      tri_cnt++;
    end
  endtask

  initial begin
    fail_cnt           = 0;
    item_cnt           = 0;
    calm               = 1'b0;
    coef_bank          = '0;
    rst_ni             = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.action       = tpf_pkg::ActLoad;
    in_ch.coef_index   = '0;
    in_ch.coef_value   = '0;
    in_ch.pixel_x      = '0;
    in_ch.pixel_y      = '0;
    in_ch.stored_depth = '0;
    out_ch.ready       = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_bank();
    test_edge_limits();
    test_depth_compare();
    test_color_wrap();
    test_index_range();
    test_random_triangles();

    in_ch.valid <= 1'b0;
    while (shade_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #200_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
